// ----- src/segment_box_clip_top_assert.svh -----
// ----------------------------------------------------------------------------
// segment_box_clip_top assertion macros
// Shared property shorthands for the clipper's pipeline checks.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_CLIP_TOP_ASSERT_SVH
`define SEGMENT_BOX_CLIP_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define SBC_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("segment_box_clip_top: check failed");

// next-cycle implication, clocked on clk, disabled in reset
`define SBC_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("segment_box_clip_top: check failed");

`endif

// ----- src/sbc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbc_pkg
// Types and fixed constants of the segment/box clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

	localparam int T_WIDTH   = 32;
	localparam int FRAC_BITS = 16;
	localparam int TOL_WIDTH = 16;
	localparam int QBITS     = T_WIDTH - 1;
	localparam int DIV_LAT   = QBITS + 2;
	localparam int MUL_LAT   = 2;
	localparam int CAP_SHIFT = 60;
	localparam int T_ONE     = 65536;

	typedef logic signed [T_WIDTH-1:0] t_t;
	typedef logic [TOL_WIDTH-1:0] tol_t;

	localparam t_t T_MAX = 32'sh7FFF_FFFF;
	localparam t_t T_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

// ----- src/sbc_div.sv -----
// ----------------------------------------------------------------------------
// sbc_div
// Pipelined restoring divider: Q16.16 quotient of num/den, one quotient
// bit per stage, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_div #(
	parameter int NW = 34,
	parameter int DW = 33
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [NW-1:0] num,
	input  wire logic signed [DW-1:0] den,
	output sbc_pkg::t_t               t
);
	import sbc_pkg::*;

	localparam int CW = (NW > DW + FRAC_BITS - 1) ? NW : DW + FRAC_BITS - 1;

	logic [NW-1:0]    n_mag;
	logic [DW-1:0]    d_mag;
	logic             neg;
	logic             ovf;

	logic [DW-1:0]    r_s   [QBITS];
	logic [QBITS-1:0] b_s   [QBITS];
	logic [DW-1:0]    d_s   [QBITS+1];
	logic [QBITS-1:0] q_s   [QBITS+1];
	logic             neg_s [QBITS+1];
	logic             ovf_s [QBITS+1];

	t_t               q_fin;

	always_comb begin
		n_mag = num[NW-1] ? (~num + 1'b1) : num;
		d_mag = den[DW-1] ? (~den + 1'b1) : den;
		neg   = num[NW-1] ^ den[DW-1];
		ovf   = CW'(n_mag) >= (CW'(d_mag) << (FRAC_BITS - 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= DW'(n_mag >> (FRAC_BITS - 1));
			b_s[0]   <= {n_mag[QBITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
			d_s[0]   <= d_mag;
			q_s[0]   <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= ovf;
		end
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		logic [DW:0] trial;
		logic        ge;

		assign trial = {r_s[k], b_s[k][QBITS-1]};
		assign ge    = trial >= {1'b0, d_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1]   <= d_s[k];
				q_s[k+1]   <= {q_s[k][QBITS-2:0], ge};
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end

		if (k < QBITS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k+1] <= ge ? DW'(trial - {1'b0, d_s[k]}) : DW'(trial);
					b_s[k+1] <= b_s[k] << 1;
				end
			end
		end
	end

	assign q_fin = t_t'({1'b0, q_s[QBITS]});

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_s[QBITS]) begin
				t <= neg_s[QBITS] ? T_MIN : T_MAX;
			end else begin
				t <= neg_s[QBITS] ? -q_fin : q_fin;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/sbc_qmul.sv -----
// ----------------------------------------------------------------------------
// sbc_qmul
// Two-stage signed Q16.16 product floor(v*t/2^16), magnitude capped at 2^60.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_qmul #(
	parameter int VW = 33
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [VW-1:0] v,
	input  wire sbc_pkg::t_t          t,
	output logic signed [VW+sbc_pkg::T_WIDTH-sbc_pkg::FRAC_BITS-1:0] p
);
	import sbc_pkg::*;

	localparam int PW = VW + T_WIDTH;
	localparam int MW = PW - FRAC_BITS;
	localparam int CW = (MW > CAP_SHIFT + 1) ? MW : CAP_SHIFT + 1;
	localparam logic [CW-1:0] CAP = CW'(1) << CAP_SHIFT;

	logic [VW-1:0]      a_mag;
	logic [T_WIDTH-1:0] b_mag;
	logic [PW-1:0]      prod_s1;
	logic               neg_s1;
	logic [MW-1:0]      m;
	logic [CW-1:0]      m_wide;
	logic [MW-1:0]      m_cap;

	always_comb begin
		a_mag = v[VW-1] ? (~v + 1'b1) : v;
		b_mag = t[T_WIDTH-1] ? (~t + 1'b1) : t;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(a_mag) * PW'(b_mag);
			neg_s1  <= v[VW-1] ^ t[T_WIDTH-1];
		end
	end

	always_comb begin
		m      = MW'(prod_s1 >> FRAC_BITS)
		       + MW'(neg_s1 && (prod_s1[FRAC_BITS-1:0] != '0));
		m_wide = CW'(m);
		m_cap  = (m_wide > CAP) ? MW'(CAP) : m;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= neg_s1 ? -$signed(m_cap) : $signed(m_cap);
		end
	end

endmodule

`default_nettype wire

// ----- src/segment_box_clip_top.sv -----
// ----------------------------------------------------------------------------
// segment_box_clip_top
// Clips a line segment against an axis-aligned box in signed Q16.16.
// ----------------------------------------------------------------------------
// The clipper takes one segment and box per cycle while in_stall is low. It
// presents the clipped segment on out_valid through 41 register stages:
// - one input register
// - 33 in the four slab dividers (a restoring divider that resolves one
//   quotient bit per stage)
// - two two-stage multiply passes (entry point, then endpoints)
// - the combine, ordering and output registers
// A stall on the result side freezes the whole pipe and raises in_stall in
// the same cycle. Bubbles travel with the data. The tolerance register resets
// to 1 and is written through cfg_valid and tolerance. Write it only while no
// transfer is in flight.
`default_nettype none

module segment_box_clip_top #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire sbc_pkg::tol_t                 tolerance,

	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_WIDTH-1:0] start_x,
	input  wire logic signed [COORD_WIDTH-1:0] start_y,
	input  wire logic signed [COORD_WIDTH-1:0] end_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_y,
	input  wire logic signed [COORD_WIDTH-1:0] box_x,
	input  wire logic signed [COORD_WIDTH-1:0] box_y,
	input  wire logic        [COORD_WIDTH-2:0] box_width,
	input  wire logic        [COORD_WIDTH-2:0] box_height,

	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0]      clip_start_x,
	output logic signed [COORD_WIDTH-1:0]      clip_start_y,
	output logic signed [COORD_WIDTH-1:0]      clip_end_x,
	output logic signed [COORD_WIDTH-1:0]      clip_end_y,
	output logic                               inside_valid
);
	import sbc_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int DW = W + 1;
	localparam int NW = W + 2;
	localparam int PW = DW + T_WIDTH - FRAC_BITS;
	localparam int XW = W + 18;
	localparam int BW = T_WIDTH + 2;

	localparam logic signed [XW-1:0] C_HI = $signed({{(XW-W+1){1'b0}}, {(W-1){1'b1}}});
	localparam logic signed [XW-1:0] C_LO = -C_HI - 1;

	typedef struct packed {
		logic                 vert;
		logic                 horiz;
		logic signed [W-1:0]  sx;
		logic signed [W-1:0]  sy;
		logic signed [W-1:0]  ox;
		logic signed [W-1:0]  oy;
		logic        [W-2:0]  w;
		logic        [W-2:0]  h;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
	} side_t;

	function automatic logic in_rng(input logic signed [XW-1:0] p,
			input logic signed [W-1:0] o, input logic [W-2:0] s, input tol_t e);
		logic signed [XW-1:0] lo;
		logic signed [XW-1:0] hi;
		lo = XW'(o) - $signed(XW'(e));
		hi = XW'(o) + $signed(XW'(s)) + $signed(XW'(e));
		return (p >= lo) && (p <= hi);
	endfunction

	function automatic logic signed [W-1:0] sat_c(input logic signed [XW-1:0] x);
		logic signed [XW-1:0] y;
		y = (x > C_HI) ? C_HI : ((x < C_LO) ? C_LO : x);
		return W'(y);
	endfunction

	function automatic logic in_band(input t_t t, input tol_t e);
		logic signed [BW-1:0] tv;
		logic signed [BW-1:0] ev;
		tv = BW'(t);
		ev = $signed(BW'(e));
		return (tv > -ev) && (tv < ev + BW'(T_ONE));
	endfunction

	logic  pipe_en;
	tol_t  tol_q;

	// stage 1: input register with differences
	logic                 v_s1;
	side_t                side_s1;
	logic signed [NW-1:0] nl_s1, nr_s1, nb_s1, nt_s1;

	// stage 2: divider-aligned side data
	logic                 v_s2    [DIV_LAT];
	side_t                side_s2 [DIV_LAT];
	side_t                side_c;
	logic [DW-1:0]        dxm, dym;
	logic                 vert_c, horiz_c;
	t_t                   tl, tr, tb, tt;

	// stage 3: slab combine
	side_t                sd;
	t_t                   mn_bt, mx_bt, g_in, g_out, g0, g1, t0_c, t1_c;
	logic                 ax_c;
	logic                 v_s3;
	side_t                side_s3;
	t_t                   t0_s3, t1_s3;
	logic                 ax_s3, gen_s3;

	// stage 4: entry-point multiply
	logic                 v_s4    [MUL_LAT];
	side_t                side_s4 [MUL_LAT];
	t_t                   t0_s4   [MUL_LAT];
	t_t                   t1_s4   [MUL_LAT];
	logic                 ax_s4   [MUL_LAT];
	logic                 gen_s4  [MUL_LAT];
	logic signed [PW-1:0] px, py;

	// stage 5: entry test and ordering
	side_t                sm;
	logic signed [XW-1:0] qx, qy;
	logic                 inside_c, swap_c;
	logic                 v_s5;
	side_t                side_s5;
	t_t                   t0_s5, t1_s5;

	// stage 6: endpoint multiply
	logic                 v_s6    [MUL_LAT];
	side_t                side_s6 [MUL_LAT];
	t_t                   t0_s6   [MUL_LAT];
	t_t                   t1_s6   [MUL_LAT];
	logic signed [PW-1:0] p0x, p0y, p1x, p1y;

	// stage 7: output select
	side_t                se;
	logic                 b0_c, b1_c;

	assign pipe_en   = !out_valid || !out_stall;
	assign in_stall  = !pipe_en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= tol_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= tolerance;
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s1.vert  <= 1'b0;
			side_s1.horiz <= 1'b0;
			side_s1.sx    <= start_x;
			side_s1.sy    <= start_y;
			side_s1.ox    <= box_x;
			side_s1.oy    <= box_y;
			side_s1.w     <= box_width;
			side_s1.h     <= box_height;
			side_s1.dx    <= DW'(end_x) - DW'(start_x);
			side_s1.dy    <= DW'(end_y) - DW'(start_y);
			nl_s1 <= NW'(box_x) - NW'(start_x);
			nr_s1 <= NW'(box_x) + $signed(NW'(box_width)) - NW'(start_x);
			nb_s1 <= NW'(box_y) - NW'(start_y);
			nt_s1 <= NW'(box_y) + $signed(NW'(box_height)) - NW'(start_y);
		end
	end

	// ---------------- stage 2: dividers ----------------
	always_comb begin
		dxm     = side_s1.dx[DW-1] ? (~side_s1.dx + 1'b1) : side_s1.dx;
		dym     = side_s1.dy[DW-1] ? (~side_s1.dy + 1'b1) : side_s1.dy;
		vert_c  = dxm < DW'(tol_q);
		horiz_c = !vert_c && (dym < DW'(tol_q));
		side_c       = side_s1;
		side_c.vert  = vert_c;
		side_c.horiz = horiz_c;
	end

	sbc_div #(.NW(NW), .DW(DW)) u_div_l (.clk, .en(pipe_en), .num(nl_s1), .den(side_s1.dx), .t(tl));
	sbc_div #(.NW(NW), .DW(DW)) u_div_r (.clk, .en(pipe_en), .num(nr_s1), .den(side_s1.dx), .t(tr));
	sbc_div #(.NW(NW), .DW(DW)) u_div_b (.clk, .en(pipe_en), .num(nb_s1), .den(side_s1.dy), .t(tb));
	sbc_div #(.NW(NW), .DW(DW)) u_div_t (.clk, .en(pipe_en), .num(nt_s1), .den(side_s1.dy), .t(tt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				v_s2[i] <= 1'b0;
			end
		end else if (pipe_en) begin
			v_s2[0] <= v_s1;
			for (int i = 1; i < DIV_LAT; i++) begin
				v_s2[i] <= v_s2[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s2[0] <= side_c;
			for (int i = 1; i < DIV_LAT; i++) begin
				side_s2[i] <= side_s2[i-1];
			end
		end
	end

	// ---------------- stage 3: combine slabs ----------------
	always_comb begin
		sd    = side_s2[DIV_LAT-1];
		mn_bt = (tt < tb) ? tt : tb;
		mx_bt = (tt > tb) ? tt : tb;
		g_in  = (sd.dx > 0) ? tl : tr;
		g_out = (sd.dx > 0) ? tr : tl;
		g0    = (g_in > mn_bt) ? g_in : mn_bt;
		g1    = (g_out < mx_bt) ? g_out : mx_bt;
		if (sd.vert) begin
			t0_c = tb;
			t1_c = tt;
			ax_c = in_rng(XW'(sd.sx), sd.ox, sd.w, tol_q);
		end else if (sd.horiz) begin
			t0_c = tl;
			t1_c = tr;
			ax_c = in_rng(XW'(sd.sy), sd.oy, sd.h, tol_q);
		end else begin
			t0_c = g0;
			t1_c = g1;
			ax_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (pipe_en) begin
			v_s3 <= v_s2[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s3 <= sd;
			t0_s3   <= t0_c;
			t1_s3   <= t1_c;
			ax_s3   <= ax_c;
			gen_s3  <= !sd.vert && !sd.horiz;
		end
	end

	// ---------------- stage 4: entry point products ----------------
	sbc_qmul #(.VW(DW)) u_mul_qx (.clk, .en(pipe_en), .v(side_s3.dx), .t(t0_s3), .p(px));
	sbc_qmul #(.VW(DW)) u_mul_qy (.clk, .en(pipe_en), .v(side_s3.dy), .t(t0_s3), .p(py));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MUL_LAT; i++) begin
				v_s4[i] <= 1'b0;
			end
		end else if (pipe_en) begin
			v_s4[0] <= v_s3;
			for (int i = 1; i < MUL_LAT; i++) begin
				v_s4[i] <= v_s4[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s4[0] <= side_s3;
			t0_s4[0]   <= t0_s3;
			t1_s4[0]   <= t1_s3;
			ax_s4[0]   <= ax_s3;
			gen_s4[0]  <= gen_s3;
			for (int i = 1; i < MUL_LAT; i++) begin
				side_s4[i] <= side_s4[i-1];
				t0_s4[i]   <= t0_s4[i-1];
				t1_s4[i]   <= t1_s4[i-1];
				ax_s4[i]   <= ax_s4[i-1];
				gen_s4[i]  <= gen_s4[i-1];
			end
		end
	end

	// ---------------- stage 5: entry test, order t ----------------
	always_comb begin
		sm = side_s4[MUL_LAT-1];
		qx = XW'(sm.sx) + XW'(px);
		qy = XW'(sm.sy) + XW'(py);
		if (gen_s4[MUL_LAT-1]) begin
			inside_c = in_rng(qx, sm.ox, sm.w, tol_q) && in_rng(qy, sm.oy, sm.h, tol_q);
		end else begin
			inside_c = ax_s4[MUL_LAT-1];
		end
		swap_c = inside_c && (t0_s4[MUL_LAT-1] > t1_s4[MUL_LAT-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (pipe_en) begin
			v_s5 <= v_s4[MUL_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s5 <= sm;
			t0_s5   <= swap_c ? t1_s4[MUL_LAT-1] : t0_s4[MUL_LAT-1];
			t1_s5   <= swap_c ? t0_s4[MUL_LAT-1] : t1_s4[MUL_LAT-1];
		end
	end

	// ---------------- stage 6: endpoint products ----------------
	sbc_qmul #(.VW(DW)) u_mul_0x (.clk, .en(pipe_en), .v(side_s5.dx), .t(t0_s5), .p(p0x));
	sbc_qmul #(.VW(DW)) u_mul_0y (.clk, .en(pipe_en), .v(side_s5.dy), .t(t0_s5), .p(p0y));
	sbc_qmul #(.VW(DW)) u_mul_1x (.clk, .en(pipe_en), .v(side_s5.dx), .t(t1_s5), .p(p1x));
	sbc_qmul #(.VW(DW)) u_mul_1y (.clk, .en(pipe_en), .v(side_s5.dy), .t(t1_s5), .p(p1y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MUL_LAT; i++) begin
				v_s6[i] <= 1'b0;
			end
		end else if (pipe_en) begin
			v_s6[0] <= v_s5;
			for (int i = 1; i < MUL_LAT; i++) begin
				v_s6[i] <= v_s6[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s6[0] <= side_s5;
			t0_s6[0]   <= t0_s5;
			t1_s6[0]   <= t1_s5;
			for (int i = 1; i < MUL_LAT; i++) begin
				side_s6[i] <= side_s6[i-1];
				t0_s6[i]   <= t0_s6[i-1];
				t1_s6[i]   <= t1_s6[i-1];
			end
		end
	end

	// ---------------- stage 7: output register ----------------
	always_comb begin
		se   = side_s6[MUL_LAT-1];
		b0_c = in_band(t0_s6[MUL_LAT-1], tol_q);
		b1_c = in_band(t1_s6[MUL_LAT-1], tol_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pipe_en) begin
			out_valid <= v_s6[MUL_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			clip_start_x <= b0_c ? sat_c(XW'(se.sx) + XW'(p0x)) : se.sx;
			clip_start_y <= b0_c ? sat_c(XW'(se.sy) + XW'(p0y)) : se.sy;
			clip_end_x   <= b1_c ? sat_c(XW'(se.sx) + XW'(p1x)) : W'(se.sx + se.dx);
			clip_end_y   <= b1_c ? sat_c(XW'(se.sy) + XW'(p1y)) : W'(se.sy + se.dy);
			inside_valid <= b0_c || b1_c
			             || ((t0_s6[MUL_LAT-1] < 0) && (t1_s6[MUL_LAT-1] > 0));
		end
	end

	`include "segment_box_clip_top_assert.svh"

	`SBC_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, v_s1)
	`SBC_ASSERT_NXT(a_stall_freezes, in_stall, $stable(v_s3) && $stable(v_s5) && $stable(out_valid))
	`SBC_ASSERT_NXT(a_tail_drains, pipe_en && v_s6[MUL_LAT-1], out_valid)

endmodule

`default_nettype wire
